@@ sv/u2u_pkg.sv @@
// Shared types and constants for the UTF-8 to 16-bit code unit decoder.
// No dependencies.
package u2u_pkg;

  // Byte classes
  localparam logic [7:0] CONT_MASK    = 8'hC0;
  localparam logic [7:0] CONT_PAT     = 8'h80;
  localparam logic [7:0] PAYLOAD_MASK = 8'h3F;
  localparam logic [7:0] ASCII_MASK   = 8'h80;
  localparam logic [7:0] NUL_BYTE     = 8'h00;

  // Widths
  localparam int unsigned BYTE_BITS = 8;
  localparam int unsigned CODE_BITS = 16;
  localparam int unsigned CONT_BITS = 6;

  // Leading-one count that marks the longest accepted lead byte (0xFE)
  localparam logic [3:0] MAX_LEAD_ONES = 4'd7;

  // One result request
  typedef struct packed {
    logic [CODE_BITS-1:0] code_unit;
    logic                 bad_input;
    logic                 string_end;
  } u2u_result_t;

endpackage

@@ sv/u2u_in_stage.sv @@
// Input register of the decoder: holds one byte request until the decode stage takes it.
// Depends on u2u_pkg.
module u2u_in_stage
  import u2u_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic [BYTE_BITS-1:0] in_byte_i,
  output logic                 in_stall_o,
  input  logic                 take_i,
  output logic                 valid_o,
  output logic [BYTE_BITS-1:0] byte_o
);

  logic                 valid_q, valid_d;
  logic [BYTE_BITS-1:0] byte_q;

  // Stall only while a held byte is not being taken
  assign in_stall_o = valid_q && !take_i;

  always_comb begin
    valid_d = valid_q;
    if (!in_stall_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      byte_q <= in_byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

@@ sv/u2u_decode.sv @@
// Decode stage: sequence state (pending count, accumulator, sticky error) and byte decode.
// Depends on u2u_pkg.
module u2u_decode
  import u2u_pkg::*;
#(
  parameter int unsigned UNIT_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  logic [BYTE_BITS-1:0] byte_i,
  output logic                 res_valid_o,
  output u2u_result_t          res_o
);

  logic [2:0]           pending_q, pending_d;
  logic [UNIT_BITS-1:0] acc_q, acc_d;
  logic                 err_q, err_d;

  logic [3:0]           lead_ones;
  logic [UNIT_BITS-1:0] acc_shift;
  logic [BYTE_BITS-1:0] lead_payload;

  // Count of leading ones in the byte, 0..8
  function automatic logic [3:0] count_lead_ones(input logic [BYTE_BITS-1:0] b);
    logic [3:0] n;
    n = 4'd8;
    for (int i = BYTE_BITS - 1; i >= 0; i--) begin
      if (!b[i] && n == 4'd8) begin
        n = 4'(BYTE_BITS - 1 - i);
      end
    end
    return n;
  endfunction

  assign lead_ones    = count_lead_ones(byte_i);
  assign lead_payload = byte_i & (8'hFF >> (lead_ones + 4'd1));
  assign acc_shift    = {acc_q[UNIT_BITS-CONT_BITS-1:0], byte_i[CONT_BITS-1:0]};

  // Next state and result
  always_comb begin
    pending_d   = pending_q;
    acc_d       = acc_q;
    err_d       = err_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (fire_i) begin
      priority if (byte_i == NUL_BYTE) begin
        // End of string: report and restart
        res_valid_o     = 1'b1;
        res_o.bad_input = err_q || (pending_q != 3'd0);
        res_o.string_end = 1'b1;
        pending_d       = 3'd0;
        acc_d           = '0;
        err_d           = 1'b0;
      end else if (err_q) begin
        // Bytes after an error are dropped
      end else if (pending_q != 3'd0) begin
        if ((byte_i & CONT_MASK) != CONT_PAT) begin
          err_d           = 1'b1;
          pending_d       = 3'd0;
          acc_d           = '0;
          res_valid_o     = 1'b1;
          res_o.bad_input = 1'b1;
        end else if (pending_q == 3'd1) begin
          pending_d       = 3'd0;
          acc_d           = '0;
          res_valid_o     = 1'b1;
          res_o.code_unit = acc_shift[CODE_BITS-1:0];
        end else begin
          pending_d = pending_q - 3'd1;
          acc_d     = acc_shift;
        end
      end else if ((byte_i & ASCII_MASK) == NUL_BYTE) begin
        res_valid_o     = 1'b1;
        res_o.code_unit = {{(CODE_BITS-BYTE_BITS){1'b0}}, byte_i};
      end else if (lead_ones >= 4'd2 && lead_ones <= MAX_LEAD_ONES) begin
        // Lead byte: load payload bits and continuation count
        pending_d = 3'(lead_ones - 4'd1);
        acc_d     = {{(UNIT_BITS-BYTE_BITS){1'b0}}, lead_payload};
      end else begin
        // Stray continuation byte or 0xFF
        err_d           = 1'b1;
        acc_d           = '0;
        res_valid_o     = 1'b1;
        res_o.bad_input = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 3'd0;
      acc_q     <= '0;
      err_q     <= 1'b0;
    end else begin
      pending_q <= pending_d;
      acc_q     <= acc_d;
      err_q     <= err_d;
    end
  end

endmodule

@@ sv/u2u_out_stage.sv @@
// Result register of the decoder: holds one result request until the consumer takes it.
// Depends on u2u_pkg.
module u2u_out_stage
  import u2u_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  u2u_result_t res_i,
  output logic        free_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output u2u_result_t res_o
);

  logic        valid_q, valid_d;
  u2u_result_t res_q;

  // Register can take a new result when empty or being drained
  assign free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (valid_q && !out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

@@ sv/utf8_to_ucs2_decoder_unit.sv @@
// UTF-8 to 16-bit code unit decoder, top level.
// A held input byte is decoded and its result, if any, loaded into the output register.
// Throughput: one byte per cycle while the result register is not stalled; the single decode
// stage between the input and result registers updates the sequence state once per byte.
// Reset: asynchronous, active low; clears pending count, accumulator, error flag and valids.
// Depends on u2u_pkg, u2u_in_stage, u2u_decode, u2u_out_stage.
module utf8_to_ucs2_decoder_unit
  import u2u_pkg::*;
#(
  parameter int unsigned UNIT_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [BYTE_BITS-1:0] in_byte_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [CODE_BITS-1:0] code_unit_o,
  output logic                 bad_input_o,
  output logic                 string_end_o
);

  logic                 held_valid;
  logic [BYTE_BITS-1:0] held_byte;
  logic                 out_free;
  logic                 fire;
  logic                 res_valid;
  u2u_result_t          res;
  u2u_result_t          out_res;

  // Decode a held byte whenever the result register can accept its result
  assign fire = held_valid && out_free;

  u2u_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_byte_i  (in_byte_i),
    .in_stall_o (in_stall_o),
    .take_i     (fire),
    .valid_o    (held_valid),
    .byte_o     (held_byte)
  );

  u2u_decode #(
    .UNIT_BITS (UNIT_BITS)
  ) u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .byte_i      (held_byte),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  u2u_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_valid),
    .res_i       (res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (out_res)
  );

  assign code_unit_o  = out_res.code_unit;
  assign bad_input_o  = out_res.bad_input;
  assign string_end_o = out_res.string_end;

endmodule

@@ tb/utf8_decode_sb_pkg.sv @@
// Scoreboard for the UTF-8 to 16-bit code unit decoder: predicts the code
// units for every accepted byte and checks the results in order.
// Depends on u2u_pkg for the result type and the byte class constants.
package utf8_decode_sb_pkg;
  import u2u_pkg::*;

  localparam int unsigned REPORT_LIMIT = 10;

  class utf8_decode_scoreboard;
    // Decoder state as seen from the byte stream
    logic [2:0]           cont_left;
    logic [CODE_BITS-1:0] accum;
    logic                 string_bad;
    u2u_result_t          expected_units[$];
    int unsigned          mismatches;

    function new();
      cont_left  = '0;
      accum      = '0;
      string_bad = 1'b0;
      mismatches = 0;
    endfunction

    // Predict the unit caused by one accepted byte; returns 0 if the byte is ignored
    function bit note_byte(logic [7:0] b);
      u2u_result_t unit;
      int unsigned ones;
      logic [7:0]  lead_payload;
      unit = '0;
      // Terminator closes the string and clears all state
      if (b == NUL_BYTE) begin
        unit.bad_input  = string_bad || (cont_left != 3'd0);
        unit.string_end = 1'b1;
        cont_left       = '0;
        accum           = '0;
        string_bad      = 1'b0;
        expected_units.push_back(unit);
        return 1'b1;
      end
      // Everything up to the terminator is dropped after an error
      if (string_bad) begin
        return 1'b0;
      end
      // Inside a sequence: only continuation bytes are allowed
      if (cont_left != 3'd0) begin
        if ((b & CONT_MASK) != CONT_PAT) begin
          string_bad      = 1'b1;
          cont_left       = '0;
          accum           = '0;
          unit.bad_input  = 1'b1;
          expected_units.push_back(unit);
          return 1'b1;
        end
        accum     = {accum[CODE_BITS-CONT_BITS-1:0], b[CONT_BITS-1:0]};
        cont_left = cont_left - 3'd1;
        if (cont_left == 3'd0) begin
          unit.code_unit = accum;
          accum          = '0;
          expected_units.push_back(unit);
        end
        return 1'b1;
      end
      // Plain 7-bit character
      if ((b & ASCII_MASK) == 8'h00) begin
        unit.code_unit = {8'h00, b};
        expected_units.push_back(unit);
        return 1'b1;
      end
      // Lead byte: count leading ones
      ones = 0;
      while (ones < BYTE_BITS && b[BYTE_BITS-1-ones]) begin
        ones++;
      end
      if (ones >= 2 && ones <= MAX_LEAD_ONES) begin
        lead_payload = b & (8'hFF >> (ones + 1));
        cont_left    = 3'(ones - 1);
        accum        = {8'h00, lead_payload};
        return 1'b1;
      end
      // Stray continuation or 0xFF
      string_bad     = 1'b1;
      accum          = '0;
      unit.bad_input = 1'b1;
      expected_units.push_back(unit);
      return 1'b1;
    endfunction

    // Compare one delivered unit with the oldest prediction
    function void check_unit(u2u_result_t got);
      u2u_result_t want;
      if (expected_units.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("unexpected unit: unit=%h bad=%b end=%b",
                   got.code_unit, got.bad_input, got.string_end);
        end
        return;
      end
      want = expected_units.pop_front();
      if (want.code_unit != got.code_unit || want.bad_input != got.bad_input ||
          want.string_end != got.string_end) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("unit mismatch: expected unit=%h bad=%b end=%b, got unit=%h bad=%b end=%b",
                   want.code_unit, want.bad_input, want.string_end,
                   got.code_unit, got.bad_input, got.string_end);
        end
      end
    endfunction

    function int unsigned units_due();
      return expected_units.size();
    endfunction
  endclass

endpackage

@@ tb/tb_top.sv @@
// Testbench top for utf8_to_ucs2_decoder_unit: directed and random UTF-8
// strings under varying idle and stall patterns, checked by the scoreboard.
// Depends on u2u_pkg and utf8_decode_sb_pkg.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import u2u_pkg::*;
  import utf8_decode_sb_pkg::*;

  localparam int unsigned RANDOM_ITEMS   = 1250;
  localparam int unsigned STRINGS_PER_PHASE = 8;
  localparam int unsigned HOLD_CYCLES    = 40;
  localparam int unsigned DRAIN_CYCLES   = 20;
  localparam int unsigned CYCLE_LIMIT    = 400000;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  logic                 clk_i        = 1'b0;
  logic                 rst_ni       = 1'b0;
  logic                 in_valid_i   = 1'b0;
  logic                 in_stall_o;
  logic [BYTE_BITS-1:0] in_byte_i    = '0;
  logic                 out_valid_o;
  logic                 out_stall_i  = 1'b0;
  logic [CODE_BITS-1:0] code_unit_o;
  logic                 bad_input_o;
  logic                 string_end_o;

  utf8_decode_scoreboard units_sb;
  idle_mode_e            idle_mode    = IDLE_NONE;
  bit                    hold_go      = 1'b0;
  int unsigned           decoded_bytes = 0;
  int unsigned           cycle_count  = 0;

  utf8_to_ucs2_decoder_unit i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_byte_i    (in_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .code_unit_o  (code_unit_o),
    .bad_input_o  (bad_input_o),
    .string_end_o (string_end_o)
  );

  // Clock
  always begin
    #5ns clk_i = 1'b1;
    #5ns clk_i = 1'b0;
  end

  // Run-time guard
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  function automatic bit sender_skips();
    case (idle_mode)
      IDLE_SENDER: return $urandom_range(0, 99) < 75;
      IDLE_BOTH:   return $urandom_range(0, 99) < 18;
      default:     return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stalls();
    case (idle_mode)
      IDLE_RECEIVER: return $urandom_range(0, 99) < 75;
      IDLE_BOTH:     return $urandom_range(0, 99) < 18;
      default:       return 1'b0;
    endcase
  endfunction

  // Offer one byte; called and returns at a falling edge
  task automatic send_byte(input logic [7:0] b);
    while (sender_skips()) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    if (units_sb.note_byte(b)) begin
      decoded_bytes++;
    end
    @(negedge clk_i);
  endtask

  // Stop offering until every predicted unit has been delivered
  task automatic wait_units_done();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (units_sb.units_due() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // One character: plain, multi-byte (2 to 7 bytes) or a stray byte
  task automatic send_char();
    int unsigned pick;
    int unsigned ones;
    logic [7:0]  lead;
    logic [7:0]  rnd;
    pick = $urandom_range(0, 99);
    rnd  = 8'($urandom);
    if (pick < 40) begin
      send_byte(8'($urandom_range(1, 127)));
      return;
    end
    if (pick >= 97) begin
      send_byte(8'($urandom_range(1, 255)));
      return;
    end
    if (pick < 60)      ones = 2;
    else if (pick < 75) ones = 3;
    else if (pick < 85) ones = 4;
    else if (pick < 90) ones = 5;
    else if (pick < 94) ones = 6;
    else                ones = 7;
    lead = (8'hFF << (8 - ones)) | (rnd & (8'hFF >> (ones + 1)));
    send_byte(lead);
    repeat (ones - 1) begin
      // Occasionally break the sequence with any byte, NUL included
      if ($urandom_range(0, 99) < 5) begin
        send_byte(8'($urandom_range(0, 255)));
      end else begin
        send_byte(CONT_PAT | (8'($urandom) & PAYLOAD_MASK));
      end
    end
  endtask

  task automatic send_random_string();
    int unsigned chars;
    chars = $urandom_range(0, 10);
    repeat (chars) begin
      send_char();
    end
    send_byte(NUL_BYTE);
  endtask

  // Receiver: random stalls plus one long hold-off whenever the idle patterns start over
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_go) begin
        hold_go = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      out_stall_i <= receiver_stalls();
    end
  end

  // Result checking
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      units_sb.check_unit('{code_unit_o, bad_input_o, string_end_o});
    end
  end

  // Stimulus
  initial begin
    logic [7:0]  directed_bytes[$];
    int unsigned strings_sent;
    units_sb = new();
    strings_sent = 0;
    // Plain chars, 2/3/7-byte sequences, good end; stray continuation then
    // ignored bytes; non-continuation inside a sequence; NUL inside a
    // sequence; 0xFF lead
    directed_bytes = '{8'h01, 8'h7F, 8'hC3, 8'hA9, 8'hEF, 8'hBF, 8'hBF,
                       8'hFE, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'h00,
                       8'h80, 8'h41, 8'hFF, 8'h00,
                       8'hC3, 8'h41, 8'h00,
                       8'hE2, 8'h82, 8'h00,
                       8'hFF, 8'h00};
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    foreach (directed_bytes[i]) begin
      send_byte(directed_bytes[i]);
    end
    wait_units_done();

    // Random strings, cycling through the idle patterns
    hold_go = 1'b1;
    while (decoded_bytes < RANDOM_ITEMS) begin
      send_random_string();
      strings_sent++;
      if (strings_sent % STRINGS_PER_PHASE == 0) begin
        wait_units_done();
        idle_mode = idle_mode.next();
        if (idle_mode == IDLE_NONE) begin
          hold_go = 1'b1;
        end
      end
    end
    wait_units_done();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (units_sb.mismatches == 0 && units_sb.units_due() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
